### design/srtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtt_pkg
// Shared types and codes for the region translation table.
// ----------------------------------------------------------------------------
package srtt_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned EntryWidth = 4 * DataWidth;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_GETP   = 3'd3,
        CMD_GETV   = 3'd4,
        CMD_ALIGN  = 3'd5,
        CMD_READ   = 3'd6,
        CMD_NONE   = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_DONE
    } t_state;

    localparam logic [DataWidth-1:0] AllOnes = '1;

endpackage

### design/section_region_translation_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// section_region_translation_table
// Ordered table of address regions with add/set/remove/read, lookup and
// align commands. Entries live in one RAM and are walked one per cycle.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | transfer when
//  ----------+-------------------------------------------+------------------
//  command   | i_start, o_busy, i_cmd .. i_index         | i_start & !o_busy
//  result    | o_done, o_status .. o_entry_phys          | o_done
//
// Add, unused commands, index errors and a repeated align go straight to
// the result without walking the RAM; read fetches its one entry. Lookup
// and remove walk the entries one RAM read per cycle, lookup newest first
// until a hit; set and an align miss walk them all. The single RAM port
// pair sets the rate: one read and one write per cycle. Remove shifts
// newer entries down as it walks.
// Reset clears the count, last align result and control only; entries
// past the count are never read. The receiver cannot stall: o_done is a
// one-cycle strobe and o_busy stays high until it has been shown, so the
// next transfer comes in the cycle after the strobe at the earliest.
// ----------------------------------------------------------------------------
module section_region_translation_table #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [2:0]                   i_cmd,
    input  logic [srtt_pkg::DataWidth-1:0] i_addr,
    input  logic [srtt_pkg::DataWidth-1:0] i_end_addr,
    input  logic [srtt_pkg::DataWidth-1:0] i_virt_base,
    input  logic [srtt_pkg::DataWidth-1:0] i_phys_base,
    input  logic [3:0]                   i_index,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic [srtt_pkg::DataWidth-1:0] o_result_value,
    output logic [srtt_pkg::DataWidth-1:0] o_entry_start,
    output logic [srtt_pkg::DataWidth-1:0] o_entry_end,
    output logic [srtt_pkg::DataWidth-1:0] o_entry_virt,
    output logic [srtt_pkg::DataWidth-1:0] o_entry_phys
);
    import srtt_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [DataWidth-1:0] r_last, n_last;

    // latched command
    t_cmd r_cmd, n_cmd;
    logic [DataWidth-1:0] r_a, r_e, r_v, r_p, n_a, n_e, n_v, n_p;

    // walk pointer, and the address of the read issued last cycle
    logic [CW-1:0] r_ptr, n_ptr;
    logic r_rd_vld, n_rd_vld;
    logic [CW-1:0] r_rd_addr, n_rd_addr;
    logic r_found, n_found;

    // result registers
    logic r_done, n_done;
    logic [1:0] r_status, n_status;
    logic [DataWidth-1:0] r_val, n_val, r_es, r_ee, r_ev, r_ep;
    logic [DataWidth-1:0] n_es, n_ee, n_ev, n_ep;

    // ram
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [EntryWidth-1:0] wdata, rdata;
    logic [DataWidth-1:0] d_s, d_e, d_v, d_p;

    srtt_ram #(.WIDTH(EntryWidth), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign {d_s, d_e, d_v, d_p} = rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_last   <= '0;
            r_done   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_last   <= n_last;
            r_done   <= n_done;
            r_rd_vld <= n_rd_vld;
        end
        r_cmd     <= n_cmd;
        r_a       <= n_a;
        r_e       <= n_e;
        r_v       <= n_v;
        r_p       <= n_p;
        r_ptr     <= n_ptr;
        r_rd_addr <= n_rd_addr;
        r_found   <= n_found;
        r_status  <= n_status;
        r_val     <= n_val;
        r_es      <= n_es;
        r_ee      <= n_ee;
        r_ev      <= n_ev;
        r_ep      <= n_ep;
    end

    logic hold;
    logic [DataWidth-1:0] cur;
    assign hold = (r_a >= d_s) && (r_a <= d_e);
    assign cur  = r_a - d_v;

    always_comb begin
        n_state = r_state;  n_count = r_count;  n_last = r_last;
        n_cmd = r_cmd;  n_a = r_a;  n_e = r_e;  n_v = r_v;  n_p = r_p;
        n_ptr = r_ptr;  n_rd_vld = 1'b0;  n_rd_addr = r_rd_addr;
        n_found = r_found;
        n_done = 1'b0;  n_status = r_status;  n_val = r_val;
        n_es = r_es;  n_ee = r_ee;  n_ev = r_ev;  n_ep = r_ep;
        we = 1'b0;  waddr = '0;  wdata = {r_a, r_e, r_v, r_p};
        raddr = r_ptr[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                // no transfer while the result strobe is up
                if (i_start && !r_done) begin
                    n_cmd = t_cmd'(i_cmd);
                    n_a = i_addr;  n_e = i_end_addr;
                    n_v = i_virt_base;  n_p = i_phys_base;
                    n_found = 1'b0;
                    n_status = ST_OK;  n_val = '0;
                    n_es = '0;  n_ee = '0;  n_ev = '0;  n_ep = '0;
                    n_state = S_SCAN;
                    unique case (t_cmd'(i_cmd))
                        CMD_ADD: begin
                            if (r_count >= DepthC) n_status = ST_FULL;
                            n_state = S_DONE;
                        end
                        CMD_SET: n_ptr = '0;
                        CMD_REMOVE: begin
                            if (CW'(i_index) >= r_count) begin
                                n_status = ST_RANGE;  n_state = S_DONE;
                            end else begin
                                n_ptr = CW'(i_index) + 1'b1;
                            end
                        end
                        CMD_GETP, CMD_GETV: begin
                            n_status = ST_NOMATCH;  n_val = AllOnes;
                            n_ptr = r_count - 1'b1;
                        end
                        CMD_ALIGN: begin
                            if (i_addr == r_last) begin
                                n_val = r_last;  n_state = S_DONE;
                            end
                            n_ptr = '0;
                        end
                        CMD_READ: begin
                            if (CW'(i_index) >= r_count) begin
                                n_status = ST_RANGE;  n_state = S_DONE;
                            end
                            n_ptr = CW'(i_index);
                        end
                        default: begin
                            n_status = ST_NOMATCH;  n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read per cycle; evaluate data from last cycle
                if (r_rd_vld) begin
                    unique case (r_cmd)
                        CMD_SET: begin
                            if (d_s == r_a) begin
                                n_found = 1'b1;  we = 1'b1;
                                waddr = r_rd_addr[AW-1:0];
                                wdata = {d_s,
                                         (r_e == AllOnes) ? d_e : r_e,
                                         (r_v == AllOnes) ? d_v : r_v,
                                         (r_p == AllOnes) ? d_p : r_p};
                            end
                        end
                        CMD_REMOVE: begin
                            we = 1'b1;
                            waddr = AW'(r_rd_addr - 1'b1);
                            wdata = rdata;
                        end
                        CMD_GETP, CMD_GETV: begin
                            if (!r_found && hold) begin
                                n_found = 1'b1;  n_status = ST_OK;
                                n_val = (r_cmd == CMD_GETP) ? d_p : d_v;
                            end
                        end
                        CMD_ALIGN: begin
                            if (!r_found && hold) begin
                                n_found = 1'b1;  n_val = cur + d_p;
                            end
                        end
                        CMD_READ: begin
                            n_es = d_s;  n_ee = d_e;  n_ev = d_v;  n_ep = d_p;
                        end
                        default: ;
                    endcase
                end
                // next read, or wrap up
                if (r_cmd == CMD_READ) begin
                    if (r_rd_vld) begin
                        n_state = S_DONE;
                    end else begin
                        n_rd_vld = 1'b1;  n_rd_addr = r_ptr;
                    end
                end else if (r_cmd == CMD_GETP || r_cmd == CMD_GETV) begin
                    if (r_ptr == '1 || r_found || n_found) begin
                        n_state = S_DONE;
                    end else begin
                        n_rd_vld = 1'b1;  n_rd_addr = r_ptr;  n_ptr = r_ptr - 1'b1;
                    end
                end else begin
                    if (r_ptr >= r_count ||
                        (r_cmd == CMD_ALIGN && (r_found || n_found))) begin
                        n_state = S_EVAL;
                    end else begin
                        n_rd_vld = 1'b1;  n_rd_addr = r_ptr;  n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                unique case (r_cmd)
                    CMD_SET: n_status = r_found ? ST_OK : ST_NOMATCH;
                    CMD_REMOVE: n_count = r_count - 1'b1;
                    CMD_ALIGN: begin
                        if (!r_found) begin
                            n_val = r_a - r_v + r_p;
                            n_last = n_val;
                            n_status = ST_NOMATCH;
                        end
                    end
                    default: ;
                endcase
            end
            S_DONE: begin
                if (r_cmd == CMD_ADD && r_status == ST_OK) begin
                    we = 1'b1;  waddr = r_count[AW-1:0];
                    n_count = r_count + 1'b1;
                end
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // busy while working or while the result strobe is up
    assign o_busy = (r_state != S_IDLE) || r_done;
    assign o_done = r_done;
    assign o_status = r_status;
    assign o_result_value = r_val;
    assign o_entry_start = r_es;
    assign o_entry_end = r_ee;
    assign o_entry_virt = r_ev;
    assign o_entry_phys = r_ep;

endmodule

### design/srtt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module srtt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, set, remove, read, lookup and align commands into the region
// translation table and checks each result against an internal table model.
// ----------------------------------------------------------------------------
module testbench;
    import srtt_pkg::*;

    localparam int Depth = 16;
    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
        logic [63:0] e_start;
        logic [63:0] e_end;
        logic [63:0] e_virt;
        logic [63:0] e_phys;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_cmd = '0;
    logic [63:0] i_addr = '0;
    logic [63:0] i_end_addr = '0;
    logic [63:0] i_virt_base = '0;
    logic [63:0] i_phys_base = '0;
    logic [3:0]  i_index = '0;
    logic        o_busy;
    logic        o_done;
    logic [1:0]  o_status;
    logic [63:0] o_result_value;
    logic [63:0] o_entry_start;
    logic [63:0] o_entry_end;
    logic [63:0] o_entry_virt;
    logic [63:0] o_entry_phys;

    // Model of the table contents
    logic [63:0] rgn_start [Depth];
    logic [63:0] rgn_end   [Depth];
    logic [63:0] rgn_virt  [Depth];
    logic [63:0] rgn_phys  [Depth];
    int          rgn_count = 0;
    logic [63:0] model_last = '0;

    t_outcome pending_results[$];
    int  fail_count = 0;
    int  cycle_count = 0;

    section_region_translation_table #(.TABLE_DEPTH(Depth)) dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic in_region(int k, logic [63:0] a);
        return a >= rgn_start[k] && a <= rgn_end[k];
    endfunction

    // Apply one command to the table model and return its outcome.
    function automatic t_outcome translate_cmd(logic [2:0] c, logic [63:0] a,
            logic [63:0] e, logic [63:0] v, logic [63:0] p, logic [3:0] idx);
        t_outcome r;
        logic hit;
        r = '0;
        case (t_cmd'(c))
            CMD_ADD: begin
                if (rgn_count >= Depth) begin
                    r.status = ST_FULL;
                end else begin
                    rgn_start[rgn_count] = a;
                    rgn_end[rgn_count] = e;
                    rgn_virt[rgn_count] = v;
                    rgn_phys[rgn_count] = p;
                    rgn_count++;
                end
            end
            CMD_SET: begin
                hit = 1'b0;
                for (int k = 0; k < rgn_count; k++) begin
                    if (rgn_start[k] == a) begin
                        hit = 1'b1;
                        if (e != AllOnes) rgn_end[k] = e;
                        if (v != AllOnes) rgn_virt[k] = v;
                        if (p != AllOnes) rgn_phys[k] = p;
                    end
                end
                r.status = hit ? ST_OK : ST_NOMATCH;
            end
            CMD_REMOVE: begin
                if (idx >= rgn_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int k = idx; k + 1 < rgn_count; k++) begin
                        rgn_start[k] = rgn_start[k+1];
                        rgn_end[k] = rgn_end[k+1];
                        rgn_virt[k] = rgn_virt[k+1];
                        rgn_phys[k] = rgn_phys[k+1];
                    end
                    rgn_count--;
                end
            end
            CMD_GETP, CMD_GETV: begin
                // newest matching region wins
                r.status = ST_NOMATCH;
                r.value = AllOnes;
                for (int k = rgn_count - 1; k >= 0; k--) begin
                    if (in_region(k, a)) begin
                        r.status = ST_OK;
                        r.value = (c == CMD_GETP) ? rgn_phys[k] : rgn_virt[k];
                        break;
                    end
                end
            end
            CMD_ALIGN: begin
                if (a == model_last) begin
                    r.value = model_last;
                end else begin
                    // oldest matching region wins; miss falls back to inputs
                    hit = 1'b0;
                    for (int k = 0; k < rgn_count; k++) begin
                        if (in_region(k, a)) begin
                            hit = 1'b1;
                            r.value = a - rgn_virt[k] + rgn_phys[k];
                            break;
                        end
                    end
                    if (!hit) begin
                        model_last = a - v + p;
                        r.value = model_last;
                        r.status = ST_NOMATCH;
                    end
                end
            end
            CMD_READ: begin
                if (idx >= rgn_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.e_start = rgn_start[idx];
                    r.e_end = rgn_end[idx];
                    r.e_virt = rgn_virt[idx];
                    r.e_phys = rgn_phys[idx];
                end
            end
            default: r.status = ST_NOMATCH;
        endcase
        return r;
    endfunction

    // Result checker: every o_done strobe is one transfer.
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && o_done) begin
            got = {o_status, o_result_value, o_entry_start, o_entry_end,
                   o_entry_virt, o_entry_phys};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status,
                             got.status);
                    fail_count++;
                end
                if (got.value !== want.value) begin
                    $display("%0t: value exp %h got %h", $time, want.value, got.value);
                    fail_count++;
                end
                if (got.e_start !== want.e_start) begin
                    $display("%0t: start exp %h got %h", $time, want.e_start,
                             got.e_start);
                    fail_count++;
                end
                if (got.e_end !== want.e_end) begin
                    $display("%0t: end exp %h got %h", $time, want.e_end, got.e_end);
                    fail_count++;
                end
                if (got.e_virt !== want.e_virt) begin
                    $display("%0t: virt exp %h got %h", $time, want.e_virt,
                             got.e_virt);
                    fail_count++;
                end
                if (got.e_phys !== want.e_phys) begin
                    $display("%0t: phys exp %h got %h", $time, want.e_phys,
                             got.e_phys);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Send one command; gap drawn 0..8, held until the transfer. The first
    // edge only lets start drop; o_busy covers it, so gap 0 is back to back.
    task automatic send_cmd(t_cmd c, logic [63:0] a, logic [63:0] e,
                            logic [63:0] v, logic [63:0] p, logic [3:0] idx);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
        i_start <= 1'b1;
        i_cmd <= c;
        i_addr <= a;
        i_end_addr <= e;
        i_virt_base <= v;
        i_phys_base <= p;
        i_index <= idx;
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(translate_cmd(c, a, e, v, p, idx));
        i_start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Index into the written entries; with allow_bad set, or on an empty table, it may overrun.
    function automatic logic [3:0] pick_index(logic allow_bad);
        if (rgn_count == 0 || (allow_bad && $urandom_range(0, 5) == 0))
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, rgn_count - 1));
    endfunction

    task automatic test_directed();
        send_cmd(CMD_READ, 0, 0, 0, 0, 4'd0);        // empty table
        send_cmd(CMD_REMOVE, 0, 0, 0, 0, 4'd15);
        send_cmd(CMD_GETP, 64'd5, 0, 0, 0, 0);       // lookup miss
        send_cmd(CMD_ALIGN, 64'd0, 0, 0, 0, 0);      // repeat of reset result
        send_cmd(CMD_ADD, 64'h100, 64'h1ff, 64'h1000, 64'h8000, 0);
        send_cmd(CMD_ADD, 64'h180, 64'h2ff, 64'h2000, 64'h9000, 0);
        send_cmd(CMD_ADD, 0, AllOnes, AllOnes, AllOnes, 0);
        send_cmd(CMD_GETP, 64'h190, 0, 0, 0, 0);     // newest wins
        send_cmd(CMD_GETV, 64'h150, 0, 0, 0, 0);
        send_cmd(CMD_ALIGN, 64'h190, 0, 0, 0, 0);    // oldest wins
        send_cmd(CMD_REMOVE, 0, 0, 0, 0, 4'd2);
        send_cmd(CMD_ALIGN, 64'h50, 64'h0, 64'h10, 64'h20, 0); // miss, stored
        send_cmd(CMD_ALIGN, 64'h60, 0, 0, 0, 0);     // repeat hits last result
        send_cmd(CMD_SET, 64'h100, AllOnes, 64'h3000, AllOnes, 0); // keep fields
        send_cmd(CMD_SET, 64'h777, 0, 0, 0, 0);      // no match
        send_cmd(CMD_READ, 0, 0, 0, 0, 4'd0);
        send_cmd(CMD_NONE, AllOnes, AllOnes, AllOnes, AllOnes, 4'hf);
        send_cmd(CMD_REMOVE, 0, 0, 0, 0, 4'd0);
        send_cmd(CMD_READ, 0, 0, 0, 0, 4'd5);
        send_cmd(CMD_GETV, AllOnes, 0, 0, 0, 0);
    endtask

    task automatic test_fill_table();
        // push past a full table, then drain it from the front
        while (rgn_count < Depth)
            send_cmd(CMD_ADD, rand64(), rand64(), rand64(), rand64(), 0);
        send_cmd(CMD_ADD, 1, 2, 3, 4, 0);
        send_cmd(CMD_READ, 0, 0, 0, 0, 4'd15);
        send_cmd(CMD_GETP, rand64(), 0, 0, 0, 0);
        wait_drained();                              // sender hold-off
        while (rgn_count > 0) send_cmd(CMD_REMOVE, 0, 0, 0, 0, 4'd0);
    endtask

    task automatic test_random(int n);
        logic [63:0] base, a, v, p;
        logic [63:0] len;
        t_cmd c;
        for (int i = 0; i < n; i++) begin
            base = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 4095));
            len = 64'($urandom_range(0, 512));
            a = (rgn_count > 0 && $urandom_range(0, 2) != 0) ?
                rgn_start[$urandom_range(0, rgn_count - 1)] + 64'($urandom_range(0, 300))
                : base;
            v = ($urandom_range(0, 7) == 0) ? AllOnes : rand64();
            p = ($urandom_range(0, 7) == 0) ? AllOnes : rand64();
            case ($urandom_range(0, 12))
                0, 1, 2: c = (rgn_count >= Depth && $urandom_range(0, 1)) ?
                             CMD_REMOVE : CMD_ADD;
                3:       c = CMD_SET;
                4:       c = CMD_REMOVE;
                5, 6:    c = CMD_GETP;
                7, 8:    c = CMD_GETV;
                9, 10:   c = CMD_ALIGN;
                11:      c = CMD_READ;
                default: c = ($urandom_range(0, 3) == 0) ? CMD_NONE : CMD_ALIGN;
            endcase
            if (c == CMD_ALIGN && $urandom_range(0, 4) == 0) a = model_last;
            if (c == CMD_SET && rgn_count > 0) a = rgn_start[$urandom_range(0, rgn_count-1)];
            // reads may overrun: out of range returns zeros
            send_cmd(c, (c == CMD_ADD) ? base : a,
                     ($urandom_range(0, 7) == 0) ? AllOnes : base + len, v, p,
                     pick_index(1'b1));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_table();
        test_random(680);
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
design/srtt_pkg.sv
design/srtt_ram.sv
design/section_region_translation_table.sv
bench/testbench.sv
